FILE: hw/rtl/lwsd_pkg.sv
// ----------------------------------------------------------------------------
// lwsd_pkg
// shared types and constants for the legacy websocket frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lwsd_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int GROUP_BITS  = 7;

    localparam logic [7:0] BYTE_DELIM = 8'hFF;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;

    typedef logic [LENGTH_BITS-1:0] len_t;

    typedef enum logic [3:0] {
        PH_TYPE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BIN  = 4'b0100,
        PH_TEXT = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_payload;
        logic       binary_frame;
        logic       frame_last;
        logic       length_overflow;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/legacy_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// legacy_websocket_frame_deframer
// splits a received byte stream into binary (length-prefixed) and text
// (0xff-delimited) frames, one byte per word
// a result, where the byte gives one, passes the input register and then the
// result register; throughput: one byte per cycle unless out_ready stalls
// a result held by out_ready low holds a full input register and lowers in_ready
// reset: asynchronous, active low; parser waits for a type byte, length zero
// ----------------------------------------------------------------------------
`default_nettype none

module legacy_websocket_frame_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       payload_byte,
    output logic             has_payload,
    output logic             binary_frame,
    output logic             frame_last,
    output logic             length_overflow
);
    import lwsd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    len_t       len_reg;
    len_t       len_next;
    logic       emit;
    result_t    result;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    logic       advance;

    lwsd_parse u_parse
    (
        .phase      (phase_reg),
        .len        (len_reg),
        .rx_byte    (in_byte_reg),
        .phase_next (phase_next),
        .len_next   (len_next),
        .emit       (emit),
        .result     (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_TYPE;
            len_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_byte    = out_reg.payload_byte;
    assign has_payload     = out_reg.has_payload;
    assign binary_frame    = out_reg.binary_frame;
    assign frame_last      = out_reg.frame_last;
    assign length_overflow = out_reg.length_overflow;

`ifndef SYNTHESIS
    // binary payload phase always has bytes still due
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BIN) |-> (len_reg != '0))
        else $error("binary payload phase with zero remaining length");

    // a frame end or overflow sends the parser back to the type byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && (result.frame_last || result.length_overflow))
            |=> (phase_reg == PH_TYPE))
        else $error("parser did not return to type phase after frame end");

    // a held input word is not dropped while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input word lost");

    // a pending result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lwsd_parse.sv
// ----------------------------------------------------------------------------
// lwsd_parse
// per-word parse step: next phase, next length and the optional result
// ----------------------------------------------------------------------------
`default_nettype none

module lwsd_parse
(
    input  wire lwsd_pkg::phase_t  phase,
    input  wire lwsd_pkg::len_t    len,
    input  wire logic [7:0]        rx_byte,
    output lwsd_pkg::phase_t       phase_next,
    output lwsd_pkg::len_t         len_next,
    output logic                   emit,
    output lwsd_pkg::result_t      result
);
    import lwsd_pkg::*;

    len_t len_grown;
    len_t len_dec;
    logic len_full;

    assign len_full  = |len[LENGTH_BITS-1:LENGTH_BITS-GROUP_BITS];
    assign len_grown = {len[LENGTH_BITS-GROUP_BITS-1:0], rx_byte[GROUP_BITS-1:0]};
    assign len_dec   = len - len_t'(1);

    always_comb
    begin
        phase_next = phase;
        len_next   = len;
        emit       = 1'b0;
        result     = '0;
        unique case (phase)
            PH_TYPE:
            begin
                len_next   = '0;
                phase_next = rx_byte[7] ? PH_LEN : PH_TEXT;
            end
            PH_LEN:
            begin
                if (rx_byte == BYTE_ZERO)
                begin
                    if (len == '0)
                    begin
                        phase_next          = PH_TYPE;
                        emit                = 1'b1;
                        result.binary_frame = 1'b1;
                        result.frame_last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BIN;
                    end
                end
                else if (len_full)
                begin
                    len_next               = '0;
                    phase_next             = PH_TYPE;
                    emit                   = 1'b1;
                    result.binary_frame    = 1'b1;
                    result.length_overflow = 1'b1;
                end
                else
                begin
                    len_next = len_grown;
                    if (!rx_byte[7])
                    begin
                        if (len_grown == '0)
                        begin
                            phase_next          = PH_TYPE;
                            emit                = 1'b1;
                            result.binary_frame = 1'b1;
                            result.frame_last   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BIN;
                        end
                    end
                end
            end
            PH_BIN:
            begin
                len_next            = len_dec;
                emit                = 1'b1;
                result.payload_byte = rx_byte;
                result.has_payload  = 1'b1;
                result.binary_frame = 1'b1;
                result.frame_last   = (len_dec == '0);
                if (len_dec == '0)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TEXT:
            begin
                emit = 1'b1;
                if (rx_byte == BYTE_DELIM)
                begin
                    phase_next        = PH_TYPE;
                    result.frame_last = 1'b1;
                end
                else
                begin
                    result.payload_byte = rx_byte;
                    result.has_payload  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_TYPE;
                len_next   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sim/lwsd_frame_check.sv
// ----------------------------------------------------------------------------
// lwsd_frame_check
// watches both channels of the deframer, keeps its own copy of the parser
// state, works out the result each accepted byte must give and compares each
// accepted result field by field with the oldest one still due
// ----------------------------------------------------------------------------
module lwsd_frame_check
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] payload_byte,
    input  logic       has_payload,
    input  logic       binary_frame,
    input  logic       frame_last,
    input  logic       length_overflow,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import lwsd_pkg::*;

    phase_t  model_phase;
    len_t    model_len;
    result_t due_results[$];

    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        bit done;
        r = '0;
        done = 1'b0;
        case (model_phase)
            PH_TYPE:
            begin
                model_len = '0;
                model_phase = b[7] ? PH_LEN : PH_TEXT;
                return 1'b0;
            end
            PH_LEN:
            begin
                if (b == BYTE_ZERO)
                begin
                    done = 1'b1;
                end
                else
                begin
                    if ((model_len >> (LENGTH_BITS - GROUP_BITS)) != '0)
                    begin
                        model_len = '0;
                        model_phase = PH_TYPE;
                        r.binary_frame = 1'b1;
                        r.length_overflow = 1'b1;
                        return 1'b1;
                    end
                    model_len = {model_len[LENGTH_BITS-GROUP_BITS-1:0], b[6:0]};
                    done = !b[7];
                end
                if (!done)
                    return 1'b0;
                if (model_len == '0)
                begin
                    model_phase = PH_TYPE;
                    r.binary_frame = 1'b1;
                    r.frame_last = 1'b1;
                    return 1'b1;
                end
                model_phase = PH_BIN;
                return 1'b0;
            end
            PH_BIN:
            begin
                model_len = model_len - 1'b1;
                r.payload_byte = b;
                r.has_payload = 1'b1;
                r.binary_frame = 1'b1;
                r.frame_last = (model_len == '0);
                if (r.frame_last)
                    model_phase = PH_TYPE;
                return 1'b1;
            end
            default:
            begin
                if (b == BYTE_DELIM)
                begin
                    model_phase = PH_TYPE;
                    r.frame_last = 1'b1;
                end
                else
                begin
                    r.payload_byte = b;
                    r.has_payload = 1'b1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            model_phase = PH_TYPE;
            model_len = '0;
            due_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t ns: unexpected word, expected none, actual %0h %b%b%b%b",
                             $time, payload_byte, has_payload, binary_frame,
                             frame_last, length_overflow);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("has_payload", want.has_payload, has_payload);
                    check_field("binary_frame", want.binary_frame, binary_frame);
                    check_field("frame_last", want.frame_last, frame_last);
                    check_field("length_overflow", want.length_overflow, length_overflow);
                end
            end
            if (in_valid && in_ready)
            begin
                if (parse_byte(rx_byte, fresh))
                    due_results = {due_results, fresh};
            end
            outstanding = due_results.size();
        end
    end

endmodule

FILE: sim/tb_legacy_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_legacy_websocket_frame_deframer
// drives a short directed byte stream (text, binary, empty, multi-group and
// overflowing lengths) and then random well-formed frames mixed with broken
// ones and noise, with random idle cycles on both channels; the checker
// instance predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_legacy_websocket_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 900;
    localparam int DIRECTED_LEN = 28;
    localparam logic [7:0] DIRECTED [0:DIRECTED_LEN-1] = '{
        8'h7F, 8'h00, 8'hFE, 8'hFF,
        8'h80, 8'h02, 8'hFF, 8'h00,
        8'hFF, 8'h00,
        8'h81, 8'h81, 8'h00, 8'h55,
        8'h80, 8'h80, 8'h01, 8'hFF,
        8'h80, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h41, 8'h42, 8'hFF
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       binary_frame;
    logic       frame_last;
    logic       length_overflow;
    int         mismatches;
    int         outstanding;
    bit         steady = 1'b0;
    int         bytes_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    legacy_websocket_frame_deframer uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_byte    (payload_byte),
        .has_payload     (has_payload),
        .binary_frame    (binary_frame),
        .frame_last      (frame_last),
        .length_overflow (length_overflow)
    );

    lwsd_frame_check checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_byte    (payload_byte),
        .has_payload     (has_payload),
        .binary_frame    (binary_frame),
        .frame_last      (frame_last),
        .length_overflow (length_overflow),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 20);

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2))
                @(negedge clk);
        end
    endtask

    initial
    begin
        int         pick;
        int         count;
        int         groups;
        int         lead;
        bit         term;
        logic [31:0] frame_len;
        logic [31:0] rest;
        logic [6:0]  grp [0:4];

        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            steady = (bytes_sent >= 400 && bytes_sent < 550);
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_byte(8'($urandom_range(0, 127)));
                count = $urandom_range(0, 8);
                repeat (count)
                    send_byte(8'($urandom_range(0, 254)));
                send_byte(BYTE_DELIM_TB());
            end
            else if (pick < 82)
            begin
                send_byte(8'($urandom_range(128, 255)));
                if ($urandom_range(0, 99) < 80)
                    frame_len = $urandom_range(0, 10);
                else
                    frame_len = $urandom_range(11, 400);
                groups = 0;
                rest = frame_len;
                while (rest != 0)
                begin
                    grp[groups] = rest[6:0];
                    rest = rest >> 7;
                    groups++;
                end
                lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                term = ($urandom_range(0, 2) == 0) || (groups == 0);
                repeat (lead)
                    send_byte(8'h80);
                for (int i = groups - 1; i >= 0; i--)
                    send_byte({!((i == 0) && !term), grp[i]});
                if (term)
                    send_byte(8'h00);
                repeat (frame_len)
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 90)
            begin
                send_byte(8'($urandom_range(128, 255)));
                send_byte(8'h80 | 8'($urandom_range(16, 127)));
                repeat (4)
                    send_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            else
            begin
                count = $urandom_range(1, 3);
                repeat (count)
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] BYTE_DELIM_TB();
        return lwsd_pkg::BYTE_DELIM;
    endfunction

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
